[hdl/sharpen_3x3_stream_assert.svh]
// ---------------------------------------------------------------------------
// sharpen_3x3_stream assertion macros
// Shared check macros for the sharpen stream; compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef SHARPEN_3X3_STREAM_ASSERT_SVH
`define SHARPEN_3X3_STREAM_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge outside reset
`define SHP_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define SHP_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SHP_ASSERT(label, cond, msg)
`define SHP_IMPLY(label, ante, cons, msg)

`endif

`endif

[hdl/sharp3_pkg.sv]
// ---------------------------------------------------------------------------
// sharp3_pkg
// Constants, field widths and register indexes of the 3x3 sharpen stream.
// ---------------------------------------------------------------------------
package sharp3_pkg;

   // default sizing of the row stores and counters
   localparam int MAX_WIDTH_DEF    = 2048;
   localparam int MAX_CHANNELS_DEF = 4;
   localparam int MAX_HEIGHT_DEF   = 4096;

   // field widths
   localparam int SAMPLE_W      = 8;
   localparam int OUT_ROW_W     = 12;
   localparam int OUT_INDEX_W   = 13;
   localparam int IMAGE_WIDTH_W = 12;
   localparam int IMAGE_HEIGHT_W = 13;
   localparam int CHANNEL_W     = 3;
   localparam int CSR_DATA_W    = 13;
   localparam int CSR_INDEX_W   = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   // register values after reset
   localparam int IMAGE_WIDTH_RST   = 640;
   localparam int IMAGE_HEIGHT_RST  = 480;
   localparam int CHANNEL_COUNT_RST = 3;

   // kernel center weight
   localparam int CENTER_GAIN = 5;

endpackage

[hdl/sharpen_3x3_stream.sv]
// ---------------------------------------------------------------------------
// sharpen_3x3_stream
// Streaming 3x3 cross sharpen over channel-interleaved raster samples.
// ---------------------------------------------------------------------------
// The block takes one sample per clock when not stalled and returns 5*center
// minus the four same-channel neighbors, saturated to 0..255, one row behind
// the input; border rows and columns read 0. Each item passes through one
// input stage (row store reads) and one output register. Items of the last
// row each cause two results (their own row's result and the zero bottom
// border) through the single output register, so the input stalls while both
// are pending; all other rows run at one item per clock unless the output
// stalls. Two row stores of MAX_WIDTH*MAX_CHANNELS bytes hold the previous
// two rows: the newer one is read at two addresses (center, right) and written
// once per cycle, the older one read once and written once. The stores have
// no clearing pass; a write to any of the three registers restarts the frame.
module sharpen_3x3_stream
   import sharp3_pkg::*;
#(
   parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int MAX_HEIGHT   = MAX_HEIGHT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_write,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   // input items
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SAMPLE_W-1:0]     req_sample,
   // result items
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [SAMPLE_W-1:0]     rsp_value,
   output logic [OUT_ROW_W-1:0]    rsp_out_row,
   output logic [OUT_INDEX_W-1:0]  rsp_out_index,
   output logic                    rsp_frame_last
);

   `include "sharpen_3x3_stream_assert.svh"

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int KW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int IW    = $clog2(DEPTH);

   // clamp helpers: return the last valid count (value minus one)
   function automatic logic [CW-1:0] width_last(input logic [IMAGE_WIDTH_W-1:0] v);
      int unsigned x;
      x = 32'(v);
      if (x < 3) x = 3;
      if (x > MAX_WIDTH) x = MAX_WIDTH;
      return CW'(x - 1);
   endfunction

   function automatic logic [RW-1:0] height_last(input logic [IMAGE_HEIGHT_W-1:0] v);
      int unsigned x;
      x = 32'(v);
      if (x < 3) x = 3;
      if (x > MAX_HEIGHT) x = MAX_HEIGHT;
      return RW'(x - 1);
   endfunction

   function automatic logic [KW-1:0] chan_last(input logic [CHANNEL_W-1:0] v);
      int unsigned x;
      x = 32'(v);
      if (x < 1) x = 1;
      if (x > MAX_CHANNELS) x = MAX_CHANNELS;
      return KW'(x - 1);
   endfunction

   // configuration (stored clamped)
   logic [CW-1:0] w_last_ff, w_last_in;
   logic [RW-1:0] h_last_ff, h_last_in;
   logic [KW-1:0] ch_last_ff, ch_last_in;
   logic          csr_hit;

   // position of the next input item
   logic [KW-1:0] chan_ff, chan_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [IW-1:0] idx_ff, idx_in;

   // handshake
   logic accept, out_free, emit, can_take;

   // input stage
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_pend_a_ff, s1_pend_a_in;
   logic                s1_pend_b_ff, s1_pend_b_in;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [IW-1:0]       s1_idx_ff;
   logic [RW-1:0]       s1_row_ff;
   logic                s1_c_first_ff, s1_c_last_ff, s1_frame_last_ff;

   // row stores and their read data
   logic [SAMPLE_W-1:0] one_row_ff  [DEPTH];
   logic [SAMPLE_W-1:0] two_rows_ff [DEPTH];
   logic [SAMPLE_W-1:0] center_rd_ff, right_rd_ff, above_rd_ff;
   logic [IW-1:0]       right_addr;

   // centers of the last few items, for the left neighbor
   logic [SAMPLE_W-1:0] hist_ff [MAX_CHANNELS];

   // kernel
   logic [SAMPLE_W-1:0] left_px, right_px;
   logic [11:0]         center_x5;
   logic signed [11:0]  sum_s;
   logic [SAMPLE_W-1:0] sharp_val;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]    rsp_value_ff;
   logic [OUT_ROW_W-1:0]   rsp_out_row_ff;
   logic [OUT_INDEX_W-1:0] rsp_out_index_ff;
   logic                   rsp_frame_last_ff;
   logic [31:0]            row_wide, idx_wide;

   // --- handshake ---
   assign accept   = req_valid & ~req_stall;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign emit     = s1_valid_ff & (s1_pend_a_ff | s1_pend_b_ff) & out_free;
   assign can_take = ~s1_valid_ff | ~(s1_pend_a_ff | s1_pend_b_ff)
                   | (out_free & ~(s1_pend_a_ff & s1_pend_b_ff));
   assign req_stall = ~can_take;

   // --- configuration writes ---
   always_comb begin
      w_last_in  = w_last_ff;
      h_last_in  = h_last_ff;
      ch_last_in = ch_last_ff;
      csr_hit    = 1'b0;
      if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               w_last_in = width_last(csr_wdata[IMAGE_WIDTH_W-1:0]);
               csr_hit   = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               h_last_in = height_last(csr_wdata[IMAGE_HEIGHT_W-1:0]);
               csr_hit   = 1'b1;
            end
            CSR_CHANNEL_COUNT: begin
               ch_last_in = chan_last(csr_wdata[CHANNEL_W-1:0]);
               csr_hit    = 1'b1;
            end
            default: csr_hit = 1'b0;
         endcase
      end
   end

   // --- raster position; a register write restarts the frame ---
   always_comb begin
      chan_in = chan_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      idx_in  = idx_ff;
      if (csr_hit) begin
         chan_in = '0;
         col_in  = '0;
         row_in  = '0;
         idx_in  = '0;
      end else if (accept) begin
         idx_in = idx_ff + 1'b1;
         if (chan_ff == ch_last_ff) begin
            chan_in = '0;
            if (col_ff == w_last_ff) begin
               col_in = '0;
               idx_in = '0;
               row_in = (row_ff == h_last_ff) ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end else begin
            chan_in = chan_ff + 1'b1;
         end
      end
   end

   // --- input stage control: pending results of the held item ---
   always_comb begin
      s1_valid_in  = accept | (s1_valid_ff & ~can_take);
      s1_pend_a_in = s1_pend_a_ff;
      s1_pend_b_in = s1_pend_b_ff;
      if (accept) begin
         s1_pend_a_in = (row_ff != '0);
         s1_pend_b_in = (row_ff == h_last_ff);
      end else if (emit) begin
         if (s1_pend_a_ff) s1_pend_a_in = 1'b0;
         else              s1_pend_b_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff    <= width_last(IMAGE_WIDTH_W'(IMAGE_WIDTH_RST));
         h_last_ff    <= height_last(IMAGE_HEIGHT_W'(IMAGE_HEIGHT_RST));
         ch_last_ff   <= chan_last(CHANNEL_W'(CHANNEL_COUNT_RST));
         chan_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         idx_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s1_pend_a_ff <= 1'b0;
         s1_pend_b_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_last_ff    <= w_last_in;
         h_last_ff    <= h_last_in;
         ch_last_ff   <= ch_last_in;
         chan_ff      <= chan_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         idx_ff       <= idx_in;
         s1_valid_ff  <= s1_valid_in;
         s1_pend_a_ff <= s1_pend_a_in;
         s1_pend_b_ff <= s1_pend_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // --- input stage payload ---
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff     <= req_sample;
         s1_idx_ff        <= idx_ff;
         s1_row_ff        <= row_ff;
         s1_c_first_ff    <= (col_ff == '0);
         s1_c_last_ff     <= (col_ff == w_last_ff);
         s1_frame_last_ff <= (row_ff == h_last_ff) && (col_ff == w_last_ff)
                             && (chan_ff == ch_last_ff);
      end
   end

   // right neighbor lies one pixel on; stay in range on the last column
   assign right_addr = (col_ff == w_last_ff) ? idx_ff
                     : idx_ff + IW'(ch_last_ff) + 1'b1;

   // newer row store: read center and right, then overwrite with the sample
   always_ff @(posedge clock) begin
      if (accept) begin
         center_rd_ff       <= one_row_ff[idx_ff];
         right_rd_ff        <= one_row_ff[right_addr];
         one_row_ff[idx_ff] <= req_sample;
      end
   end

   // older row store: read above; the held center moves down a row
   always_ff @(posedge clock) begin
      if (accept) begin
         above_rd_ff <= two_rows_ff[idx_ff];
      end
      if (s1_valid_ff) begin
         two_rows_ff[s1_idx_ff] <= center_rd_ff;
      end
   end

   // center history, newest first
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_ff[0] <= center_rd_ff;
         for (int j = 1; j < MAX_CHANNELS; j++) begin
            hist_ff[j] <= hist_ff[j-1];
         end
      end
   end

   // --- kernel and saturation ---
   always_comb begin
      left_px   = s1_c_first_ff ? '0 : hist_ff[ch_last_ff];
      right_px  = s1_c_last_ff ? '0 : right_rd_ff;
      center_x5 = 12'(CENTER_GAIN) * {4'b0, center_rd_ff};
      sum_s     = $signed(center_x5) - $signed({4'b0, left_px})
                - $signed({4'b0, right_px}) - $signed({4'b0, above_rd_ff})
                - $signed({4'b0, s1_sample_ff});
      if (sum_s < 0)        sharp_val = '0;
      else if (sum_s > 255) sharp_val = 8'hFF;
      else                  sharp_val = sum_s[7:0];
   end

   // --- output register ---
   assign rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);
   assign row_wide = s1_pend_a_ff ? 32'(s1_row_ff - 1'b1) : 32'(s1_row_ff);
   assign idx_wide = 32'(s1_idx_ff);

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_out_row_ff   <= row_wide[OUT_ROW_W-1:0];
         rsp_out_index_ff <= idx_wide[OUT_INDEX_W-1:0];
         if (s1_pend_a_ff) begin
            // result for the row above; top row and side columns are border
            rsp_value_ff      <= (s1_row_ff == RW'(1) || s1_c_first_ff || s1_c_last_ff)
                                 ? '0 : sharp_val;
            rsp_frame_last_ff <= 1'b0;
         end else begin
            // bottom border result
            rsp_value_ff      <= '0;
            rsp_frame_last_ff <= s1_frame_last_ff;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_out_row    = rsp_out_row_ff;
   assign rsp_out_index  = rsp_out_index_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

   // --- assertions ---
   `SHP_IMPLY(a_last_row_dual, accept && row_ff == h_last_ff, s1_pend_a_ff && s1_pend_b_ff, "last-row item lost one of its two results")
   `SHP_ASSERT(a_pos_range, col_ff <= w_last_ff && chan_ff <= ch_last_ff && row_ff <= h_last_ff, "raster position beyond frame")
   `SHP_ASSERT(a_pend_held, s1_valid_ff || !(s1_pend_a_ff || s1_pend_b_ff), "pending result without held item")
   `SHP_ASSERT(a_last_zero, !(rsp_valid_ff && rsp_frame_last_ff) || rsp_value_ff == '0, "frame end result not on border")

endmodule
